FILE: rtl/pscrl_pkg.sv
// shared types and constants of the per-source connection rate limiter
package pscrl_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_EXT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRUNE_IVL    = 3'd5;

    localparam logic [19:0] RST_BURST_WINDOW = 20'd5000;
    localparam logic [19:0] RST_FAST_GAP     = 20'd500;
    localparam logic [2:0]  RST_BURST_LIMIT  = 3'd5;
    localparam logic [19:0] RST_BLOCK_DUR    = 20'd3000;
    localparam logic [19:0] RST_BLOCK_EXT    = 20'd250;
    localparam logic [23:0] RST_PRUNE_IVL    = 24'd60000;

    typedef struct packed {
        logic [31:0] client_ip;
        logic [47:0] now_ms;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic table_full;
    } result_t;

    typedef struct packed {
        logic [19:0] burst_window_ms;
        logic [19:0] fast_gap_ms;
        logic [2:0]  burst_limit;
        logic [19:0] block_duration_ms;
        logic [19:0] block_extension_ms;
        logic [23:0] prune_interval_ms;
    } cfg_t;

endpackage

FILE: rtl/pscrl_queue.sv
// two-entry queue between the front and the back
module pscrl_queue #(
    parameter int WIDTH = 81
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end
endmodule

FILE: rtl/pscrl_front.sv
// front end: accepts attempts and decides whether a prune sweep is due
module pscrl_front
    import pscrl_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  item_t                 s_data,
    input  logic [23:0]           prune_interval_ms,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [TIME_BITS+32:0] q_data
);
    logic [TIME_BITS-1:0] last_sweep_reg;
    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] since;
    logic                 sweep_due;

    assign now_wide  = {16'd0, s_data.now_ms};
    assign now_t     = now_wide[TIME_BITS-1:0];
    assign since     = (now_t >= last_sweep_reg) ? now_t - last_sweep_reg : '0;
    assign sweep_due = since >= {{(TIME_BITS-24){1'b0}}, prune_interval_ms};
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;
    assign q_data    = {sweep_due, now_t, s_data.client_ip};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sweep_reg <= '0;
        end else if (q_push && sweep_due) begin
            last_sweep_reg <= now_t;
        end
    end
endmodule

FILE: rtl/pscrl_back.sv
// back end: table scan with pruning, entry update and result register
module pscrl_back
    import pscrl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  q_not_empty,
    input  logic [TIME_BITS+32:0] q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    typedef struct packed {
        logic [31:0]          addr;
        logic [TIME_BITS-1:0] last;
        logic [TIME_BITS-1:0] block_until;
        logic [2:0]           count;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [31:0]          ip_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 sweep_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 hit_found_reg, free_found_reg;
    logic [IDX_W-1:0]     hit_idx_reg, free_idx_reg;
    entry_t               hit_data_reg;
    logic                 m_valid_reg;
    result_t              m_data_reg;

    logic [TIME_BITS-1:0] win_ext, fast_ext;
    logic [TIME_BITS-1:0] age;
    logic                 stale, live;
    logic                 upd_go;

    // update datapath
    logic                 blocked;
    logic [TIME_BITS-1:0] gap;
    logic [3:0]           cnt_inc;
    logic [TIME_BITS-1:0] sat_base;
    logic [19:0]          sat_inc;
    logic [TIME_BITS:0]   sat_sum;
    logic [TIME_BITS-1:0] sat_res;
    entry_t               wr_entry;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    result_t              res;

    assign win_ext  = {{(TIME_BITS-20){1'b0}}, cfg.burst_window_ms};
    assign fast_ext = {{(TIME_BITS-20){1'b0}}, cfg.fast_gap_ms};

    assign age   = (now_reg >= rd_data_reg.last) ? now_reg - rd_data_reg.last : '0;
    assign stale = valid_reg[idx_reg] && sweep_reg &&
                   (rd_data_reg.block_until <= now_reg) && (age > win_ext);
    assign live  = valid_reg[idx_reg] && !stale;

    assign q_pop  = (state_reg == S_IDLE) && q_not_empty;
    assign upd_go = (state_reg == S_UPDATE) && (!m_valid_reg || m_ready);

    assign blocked = hit_data_reg.block_until > now_reg;
    assign gap     = (now_reg >= hit_data_reg.last) ? now_reg - hit_data_reg.last : '0;
    assign cnt_inc = {1'b0, hit_data_reg.count} + 4'd1;
    assign sat_base = blocked ? hit_data_reg.block_until : now_reg;
    assign sat_inc  = blocked ? cfg.block_extension_ms : cfg.block_duration_ms;
    assign sat_sum  = {1'b0, sat_base} + {{(TIME_BITS-19){1'b0}}, sat_inc};
    assign sat_res  = (sat_sum >= {1'b0, TMAX}) ? TMAX : sat_sum[TIME_BITS-1:0];

    always_comb begin
        wr_entry = hit_data_reg;
        wr_en    = 1'b0;
        wr_idx   = hit_idx_reg;
        res.accepted   = 1'b1;
        res.table_full = 1'b0;
        if (!hit_found_reg) begin
            if (free_found_reg) begin
                wr_en  = 1'b1;
                wr_idx = free_idx_reg;
                wr_entry.addr        = ip_reg;
                wr_entry.last        = now_reg;
                wr_entry.block_until = '0;
                wr_entry.count       = 3'd1;
            end else begin
                res.table_full = 1'b1;
            end
        end else if (blocked) begin
            wr_en = 1'b1;
            wr_entry.block_until = sat_res;
            res.accepted = 1'b0;
        end else begin
            wr_en = 1'b1;
            wr_entry.last = now_reg;
            if (gap <= win_ext) begin
                if (cnt_inc > {1'b0, cfg.burst_limit}) begin
                    wr_entry.count = 3'd0;
                    if (gap <= fast_ext) begin
                        wr_entry.block_until = sat_res;
                        res.accepted = 1'b0;
                    end
                end else begin
                    wr_entry.count = cnt_inc[2:0];
                end
            end else begin
                wr_entry.count = 3'd1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_not_empty) state_next = S_READ;
            S_READ:   state_next = S_CHECK;
            S_CHECK:  state_next = (idx_reg == LAST_IDX) ? S_UPDATE : S_READ;
            S_UPDATE: if (upd_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CHECK && stale) valid_reg[idx_reg] <= 1'b0;
            if (upd_go && !hit_found_reg && free_found_reg) valid_reg[free_idx_reg] <= 1'b1;
            if (upd_go) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ip_reg         <= q_data[31:0];
            now_reg        <= q_data[TIME_BITS+31:32];
            sweep_reg      <= q_data[TIME_BITS+32];
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (state_reg == S_READ) rd_data_reg <= mem[idx_reg];
        if (state_reg == S_CHECK) begin
            if (live && !hit_found_reg && rd_data_reg.addr == ip_reg) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= idx_reg;
                hit_data_reg  <= rd_data_reg;
            end
            if (!live && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (upd_go && wr_en) mem[wr_idx] <= wr_entry;
        if (upd_go) m_data_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_hit_still_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE && hit_found_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit entry not valid at update");
    a_free_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE && !hit_found_reg && free_found_reg)
        |-> !valid_reg[free_idx_reg])
        else $error("insert slot already in use");
    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> $past(state_reg) == S_READ)
        else $error("check without a table read");
endmodule

FILE: rtl/per_source_connection_rate_limiter_top.sv
// top level of the per-source connection rate limiter
// usage:
// - input channel s_valid/s_ready/s_data carries one connection attempt per
//   transaction: source address and current millisecond time
// - result channel m_valid/m_ready/m_data returns one accept/reject verdict
//   per attempt, in order, with a flag when a new source found no free entry
// - cfg_wr_en/cfg_addr/cfg_wr_data write the six limiter registers while idle
// timing:
// - the time from an attempt's input transaction to its result is set by the scan
//   of the source table through its one read port (a read state and a check state
//   per entry, pruning in the same pass), followed by the update state
// - the back end takes a new attempt once done with the last; a two-entry queue
//   lets attempts be taken while the table scan is busy
// reset:
// - clears every entry valid bit, the last sweep time and the queue, and
//   loads the register defaults; no clearing pass is needed
// stall:
// - a stalled receiver holds the result register; the back end waits before
//   its update, and the front keeps taking attempts until the queue fills
module per_source_connection_rate_limiter_top
    import pscrl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  item_t                 s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);
    cfg_t cfg_reg;

    logic                  q_push, q_full, q_pop, q_not_empty;
    logic [TIME_BITS+32:0] q_in, q_out;

    // register file, out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.burst_window_ms    <= RST_BURST_WINDOW;
            cfg_reg.fast_gap_ms        <= RST_FAST_GAP;
            cfg_reg.burst_limit        <= RST_BURST_LIMIT;
            cfg_reg.block_duration_ms  <= RST_BLOCK_DUR;
            cfg_reg.block_extension_ms <= RST_BLOCK_EXT;
            cfg_reg.prune_interval_ms  <= RST_PRUNE_IVL;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BURST_WINDOW: cfg_reg.burst_window_ms    <= cfg_wr_data[19:0];
                REG_FAST_GAP:     cfg_reg.fast_gap_ms        <= cfg_wr_data[19:0];
                REG_BURST_LIMIT:  cfg_reg.burst_limit        <= cfg_wr_data[2:0];
                REG_BLOCK_DUR:    cfg_reg.block_duration_ms  <= cfg_wr_data[19:0];
                REG_BLOCK_EXT:    cfg_reg.block_extension_ms <= cfg_wr_data[19:0];
                REG_PRUNE_IVL:    cfg_reg.prune_interval_ms  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // front: takes attempts, marks those that start a prune sweep
    pscrl_front #(.TIME_BITS(TIME_BITS)) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .prune_interval_ms (cfg_reg.prune_interval_ms),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_data            (q_in)
    );

    // decoupling queue
    pscrl_queue #(.WIDTH(TIME_BITS + 33)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    // back: table scan, update and result register
    pscrl_back #(.TABLE_DEPTH(TABLE_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule
